/* rtl/core/pbp_pkg.sv */
// Shared types and constants for the perceptron branch predictor.
package pbp_pkg;

   localparam int WEIGHT_W = 8;
   localparam int THRESH_W = 11;
   localparam int SUM_OUT_W = 12;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 11'd33;
   localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = 8'sd127;
   localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = -8'sd128;

   localparam logic OP_PREDICT = 1'b0;
   localparam logic OP_TRAIN = 1'b1;

   typedef struct packed {
      logic pop;
      logic clearing;
   } bk_status_type;

endpackage

/* rtl/core/pbp_front.sv */
// Front end: accepts request beats, selects the weight row and queues the work.
module pbp_front #(
   parameter int HIST_LEN = 10,
   parameter int CORES = 4,
   localparam int DEPTH = CORES << HIST_LEN,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic                req_operation,
   input  logic [1:0]          req_core_id,
   input  logic [31:0]         req_branch_address,
   input  logic [9:0]          req_global_history,
   input  logic                req_actual_taken,
   input  pbp_pkg::bk_status_type bk_status,
   output logic                q_valid,
   output logic                q_operation,
   output logic                q_taken,
   output logic [HIST_LEN-1:0] q_hist,
   output logic [ADDR_W-1:0]   q_addr
);

   localparam int ENT_W = 2 + HIST_LEN + ADDR_W;

   logic [ENT_W-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic [1:0]       core_mod;
   logic [HIST_LEN+9:0] hist_wide;
   logic [ENT_W-1:0] new_entry;
   logic             push_ok;

   always_comb begin
      core_mod = req_core_id;
      for (int i = 0; i < 3; i++) begin
         if (int'(core_mod) >= CORES) begin
            core_mod = 2'(int'(core_mod) - CORES);
         end
      end
   end

   assign hist_wide = {{HIST_LEN{1'b0}}, req_global_history};
   assign new_entry = {req_operation, req_actual_taken, hist_wide[HIST_LEN-1:0],
                       ADDR_W'({core_mod, req_branch_address[HIST_LEN-1:0]})};

   assign req_full = bk_status.clearing || (count_ff == 2'd2);
   assign push_ok = req_push && !req_full;

   assign q_valid = (count_ff != 2'd0);
   assign {q_operation, q_taken, q_hist, q_addr} = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_ok;
      rd_ptr_in = rd_ptr_ff ^ bk_status.pop;
      count_in = count_ff + 2'(push_ok) - 2'(bk_status.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

/* rtl/core/pbp_back.sv */
// Back end: weight memory, weighted sum, training write-back and result queue.
module pbp_back #(
   parameter int HIST_LEN = 10,
   parameter int CORES = 4,
   localparam int DEPTH = CORES << HIST_LEN,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [pbp_pkg::THRESH_W-1:0] threshold,
   input  logic                q_valid,
   input  logic                q_operation,
   input  logic                q_taken,
   input  logic [HIST_LEN-1:0] q_hist,
   input  logic [ADDR_W-1:0]   q_addr,
   output pbp_pkg::bk_status_type bk_status,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic                rsp_predict_taken,
   output logic signed [pbp_pkg::SUM_OUT_W-1:0] rsp_weighted_sum,
   output logic                rsp_row_trained
);

   localparam int NTERMS = HIST_LEN + 1;
   localparam int ROW_W = NTERMS * pbp_pkg::WEIGHT_W;
   localparam int NG = (NTERMS + 3) / 4;
   localparam int PART_W = 11;
   localparam int SUM_W = 9 + $clog2(NTERMS);
   localparam int CMP_W = (SUM_W > pbp_pkg::THRESH_W) ? SUM_W : pbp_pkg::THRESH_W;
   localparam int RES_W = 2 + pbp_pkg::SUM_OUT_W;

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_PART, ST_FIN} state_type;

   state_type state_ff;
   logic [ROW_W-1:0]  mem [DEPTH];
   logic [ROW_W-1:0]  rd_data_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [ADDR_W-1:0] clr_ff;
   logic              op_ff, taken_ff;
   logic [NTERMS-1:0] sgn_ff;
   logic signed [PART_W-1:0] part_ff [NG];
   logic signed [PART_W-1:0] part_in [NG];
   logic signed [SUM_W-1:0]  sum;
   logic [SUM_W-1:0]  mag;
   logic              pred, train, changed;
   logic [ROW_W-1:0]  new_row;
   logic              start, mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [ROW_W-1:0]  mem_wdata;
   logic [RES_W-1:0]  res_ff [2];
   logic              res_wr_ff, res_rd_ff;
   logic [1:0]        res_cnt_ff;
   logic              res_push, res_pop;

   assign start = (state_ff == ST_IDLE) && q_valid && (res_cnt_ff != 2'd2);
   assign bk_status.pop = start;
   assign bk_status.clearing = (state_ff == ST_CLEAR);

   always_comb begin
      logic signed [PART_W-1:0] acc;
      logic signed [PART_W-1:0] w;
      int j;
      for (int g = 0; g < NG; g++) begin
         acc = '0;
         for (int k = 0; k < 4; k++) begin
            j = g * 4 + k;
            if (j < NTERMS) begin
               w = PART_W'(signed'(rd_data_ff[8*j +: 8]));
               acc = sgn_ff[j] ? acc + w : acc - w;
            end
         end
         part_in[g] = acc;
      end
   end

   always_comb begin
      logic signed [pbp_pkg::WEIGHT_W-1:0] w;
      logic up;
      sum = '0;
      for (int g = 0; g < NG; g++) begin
         sum = sum + SUM_W'(part_ff[g]);
      end
      pred = (sum > 0);
      mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
      train = (op_ff == pbp_pkg::OP_TRAIN) &&
              ((pred != taken_ff) || (CMP_W'(mag) < CMP_W'(threshold)));
      changed = 1'b0;
      new_row = rd_data_ff;
      for (int j = 0; j < NTERMS; j++) begin
         w = signed'(rd_data_ff[8*j +: 8]);
         up = (sgn_ff[j] == taken_ff);
         if (up && w != pbp_pkg::WEIGHT_MAX) begin
            new_row[8*j +: 8] = w + 8'sd1;
            changed = 1'b1;
         end else if (!up && w != pbp_pkg::WEIGHT_MIN) begin
            new_row[8*j +: 8] = w - 8'sd1;
            changed = 1'b1;
         end
      end
      changed = changed && train;
   end

   assign res_push = (state_ff == ST_FIN);
   assign res_pop = rsp_pop && !rsp_empty;
   assign mem_we = bk_status.clearing || (res_push && train);
   assign mem_waddr = bk_status.clearing ? clr_ff : addr_ff;
   assign mem_wdata = bk_status.clearing ? '0 : new_row;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (start) begin
         rd_data_ff <= mem[q_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + ADDR_W'(1);
               if (clr_ff == ADDR_W'(DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_PART;
               end
            end
            ST_PART: state_ff <= ST_FIN;
            ST_FIN: state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         addr_ff <= q_addr;
         op_ff <= q_operation;
         taken_ff <= q_taken;
         sgn_ff <= {q_hist, 1'b1};
      end
      if (state_ff == ST_PART) begin
         part_ff <= part_in;
      end
      if (res_push) begin
         res_ff[res_wr_ff] <= {pred, changed, sum[pbp_pkg::SUM_OUT_W-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_wr_ff <= 1'b0;
         res_rd_ff <= 1'b0;
         res_cnt_ff <= 2'd0;
      end else begin
         res_wr_ff <= res_wr_ff ^ res_push;
         res_rd_ff <= res_rd_ff ^ res_pop;
         res_cnt_ff <= res_cnt_ff + 2'(res_push) - 2'(res_pop);
      end
   end

   assign rsp_empty = (res_cnt_ff == 2'd0);
   assign {rsp_predict_taken, rsp_row_trained, rsp_weighted_sum} = res_ff[res_rd_ff];

   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      bk_status.clearing |-> !bk_status.pop) else $error("pop during clear");
   a_res_cnt: assert property (@(posedge clock) disable iff (reset)
      res_cnt_ff != 2'd3) else $error("result queue overflow");
   a_fin_idle: assert property (@(posedge clock) disable iff (reset)
      res_push |=> state_ff == ST_IDLE) else $error("bad state after result");
   a_start_fin: assert property (@(posedge clock) disable iff (reset)
      start |=> ##1 res_push) else $error("item did not finish");

endmodule

/* rtl/core/perceptron_branch_predictor.sv */
// An accepted request beat passes the front-end queue, memory read register,
// partial-sum registers and result queue before its response beat is offered.
// The back end takes one item at a time through its memory read, partial-sum and
// final-sum/write-back steps. Reset: synchronous; afterwards the CORES * 2^HIST_LEN
// weight rows (4096 by default) are cleared one row per cycle; req_full stays high.
module perceptron_branch_predictor #(
   parameter int HIST_LEN = 10,
   parameter int CORES = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_operation,
   input  logic [1:0]  req_core_id,
   input  logic [31:0] req_branch_address,
   input  logic [9:0]  req_global_history,
   input  logic        req_actual_taken,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_predict_taken,
   output logic signed [11:0] rsp_weighted_sum,
   output logic        rsp_row_trained,
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data
);

   localparam int ADDR_W = $clog2(CORES << HIST_LEN);

   pbp_pkg::bk_status_type bk_status;
   logic [pbp_pkg::THRESH_W-1:0] threshold_ff;
   logic                q_valid, q_operation, q_taken;
   logic [HIST_LEN-1:0] q_hist;
   logic [ADDR_W-1:0]   q_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= pbp_pkg::THRESH_RESET;
      end else if (csr_wr_en) begin
         threshold_ff <= csr_wr_data;
      end
   end

   pbp_front #(.HIST_LEN(HIST_LEN), .CORES(CORES)) u_front (
      .clock, .reset, .req_push, .req_full, .req_operation, .req_core_id,
      .req_branch_address, .req_global_history, .req_actual_taken, .bk_status,
      .q_valid, .q_operation, .q_taken, .q_hist, .q_addr
   );

   pbp_back #(.HIST_LEN(HIST_LEN), .CORES(CORES)) u_back (
      .clock, .reset, .threshold(threshold_ff), .q_valid, .q_operation, .q_taken,
      .q_hist, .q_addr, .bk_status, .rsp_empty, .rsp_pop, .rsp_predict_taken,
      .rsp_weighted_sum, .rsp_row_trained
   );

endmodule
